// ===== sv/sorted_priority_list_core_macros.svh =====
// Assertion macros for the sorted priority list.
`ifndef SORTED_PRIORITY_LIST_CORE_MACROS_SVH
`define SORTED_PRIORITY_LIST_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SPL_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("spl assertion failed");
`define SPL_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("spl assertion failed");
`else
`define SPL_ASSERT_IMPL(label, clk, rst_n, a, b)
`define SPL_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/spl_pkg.sv =====
`timescale 1ns / 1ps
package spl_pkg;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int OCC_W = 7;
  localparam int UOP_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DECREASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  // datapath micro-operations
  localparam logic [UOP_W-1:0] UOP_NONE       = 5'd0;
  localparam logic [UOP_W-1:0] UOP_LOAD       = 5'd1;
  localparam logic [UOP_W-1:0] UOP_ST_PRESENT = 5'd2;
  localparam logic [UOP_W-1:0] UOP_ST_NFOUND  = 5'd3;
  localparam logic [UOP_W-1:0] UOP_ST_FULL    = 5'd4;
  localparam logic [UOP_W-1:0] UOP_ST_EMPTY   = 5'd5;
  localparam logic [UOP_W-1:0] UOP_CLEAR      = 5'd6;
  localparam logic [UOP_W-1:0] UOP_RD_CUR     = 5'd7;
  localparam logic [UOP_W-1:0] UOP_SCAN_STEP  = 5'd8;
  localparam logic [UOP_W-1:0] UOP_INS_START  = 5'd9;
  localparam logic [UOP_W-1:0] UOP_WR_DOWN    = 5'd10;
  localparam logic [UOP_W-1:0] UOP_PUT_NEW    = 5'd11;
  localparam logic [UOP_W-1:0] UOP_INS_PUT    = 5'd12;
  localparam logic [UOP_W-1:0] UOP_RD_PREV    = 5'd13;
  localparam logic [UOP_W-1:0] UOP_RD_NEXT    = 5'd14;
  localparam logic [UOP_W-1:0] UOP_WR_UP      = 5'd15;
  localparam logic [UOP_W-1:0] UOP_CNT_DEC    = 5'd16;
  localparam logic [UOP_W-1:0] UOP_POP_CAP    = 5'd17;
  localparam logic [UOP_W-1:0] UOP_EMIT       = 5'd18;

  typedef struct packed {
    logic [UOP_W-1:0] uop;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             count_zero;
    logic             full;
    logic             idx_eq_count;
    logic             idx_eq_pos;
    logic             idx_zero;
    logic             idx_last;
    logic             id_match;
    logic             key_lt;
    logic             out_free;
  } dp_stat_t;
endpackage

// ===== sv/spl_ctrl.sv =====
`timescale 1ns / 1ps
module spl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spl_pkg::dp_stat_t stat,
  output spl_pkg::ctl_cmd_t ctl
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_CK = 4'd3;
  localparam logic [3:0] S_UP_RD   = 4'd4;
  localparam logic [3:0] S_UP_WR   = 4'd5;
  localparam logic [3:0] S_BUB_RD  = 4'd6;
  localparam logic [3:0] S_BUB_CK  = 4'd7;
  localparam logic [3:0] S_CL_RD   = 4'd8;
  localparam logic [3:0] S_CL_WR   = 4'd9;
  localparam logic [3:0] S_POP_CK  = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.uop   = spl_pkg::UOP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.uop   = spl_pkg::UOP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.cmd)
          spl_pkg::CMD_INSERT, spl_pkg::CMD_DECREASE, spl_pkg::CMD_REMOVE:
            state_nxt = S_SCAN_RD;
          spl_pkg::CMD_POP: begin
            if (stat.count_zero) begin
              ctl.uop   = spl_pkg::UOP_ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              ctl.uop   = spl_pkg::UOP_RD_CUR;
              state_nxt = S_POP_CK;
            end
          end
          spl_pkg::CMD_CLEAR: begin
            ctl.uop   = spl_pkg::UOP_CLEAR;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        if (stat.idx_eq_count) begin
          if (stat.cmd != spl_pkg::CMD_INSERT) begin
            ctl.uop   = spl_pkg::UOP_ST_NFOUND;
            state_nxt = S_DONE;
          end else if (stat.full) begin
            ctl.uop   = spl_pkg::UOP_ST_FULL;
            state_nxt = S_DONE;
          end else begin
            ctl.uop   = spl_pkg::UOP_INS_START;
            state_nxt = S_UP_RD;
          end
        end else begin
          ctl.uop   = spl_pkg::UOP_RD_CUR;
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (stat.id_match) begin
          if (stat.cmd == spl_pkg::CMD_INSERT) begin
            ctl.uop   = spl_pkg::UOP_ST_PRESENT;
            state_nxt = S_DONE;
          end else if (stat.cmd == spl_pkg::CMD_DECREASE) begin
            state_nxt = S_BUB_RD;
          end else begin
            state_nxt = S_CL_RD;
          end
        end else begin
          ctl.uop   = spl_pkg::UOP_SCAN_STEP;
          state_nxt = S_SCAN_RD;
        end
      end
      S_UP_RD: begin
        if (stat.idx_eq_pos) begin
          ctl.uop   = spl_pkg::UOP_INS_PUT;
          state_nxt = S_DONE;
        end else begin
          ctl.uop   = spl_pkg::UOP_RD_PREV;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        ctl.uop   = spl_pkg::UOP_WR_DOWN;
        state_nxt = S_UP_RD;
      end
      S_BUB_RD: begin
        if (stat.idx_zero) begin
          ctl.uop   = spl_pkg::UOP_PUT_NEW;
          state_nxt = S_DONE;
        end else begin
          ctl.uop   = spl_pkg::UOP_RD_PREV;
          state_nxt = S_BUB_CK;
        end
      end
      S_BUB_CK: begin
        if (stat.key_lt) begin
          ctl.uop   = spl_pkg::UOP_WR_DOWN;
          state_nxt = S_BUB_RD;
        end else begin
          ctl.uop   = spl_pkg::UOP_PUT_NEW;
          state_nxt = S_DONE;
        end
      end
      S_CL_RD: begin
        if (stat.idx_last) begin
          ctl.uop   = spl_pkg::UOP_CNT_DEC;
          state_nxt = S_DONE;
        end else begin
          ctl.uop   = spl_pkg::UOP_RD_NEXT;
          state_nxt = S_CL_WR;
        end
      end
      S_CL_WR: begin
        ctl.uop   = spl_pkg::UOP_WR_UP;
        state_nxt = S_CL_RD;
      end
      S_POP_CK: begin
        ctl.uop   = spl_pkg::UOP_POP_CAP;
        state_nxt = S_CL_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.uop   = spl_pkg::UOP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== sv/spl_datapath.sv =====
`timescale 1ns / 1ps
module spl_datapath #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spl_pkg::ctl_cmd_t           ctl,
  output spl_pkg::dp_stat_t           stat,
  input  logic [spl_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ID_BITS-1:0]          in_entry_id,
  input  logic [KEY_BITS-1:0]         in_cost_key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spl_pkg::ST_W-1:0]    out_status,
  output logic [ID_BITS-1:0]          out_id,
  output logic [KEY_BITS-1:0]         out_cost,
  output logic [spl_pkg::OCC_W-1:0]   out_occupancy
);
  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0] keys_mem [CAPACITY];
  logic [ID_BITS-1:0]  ids_mem  [CAPACITY];

  logic [spl_pkg::CMD_W-1:0] cmd_r;
  logic [ID_BITS-1:0]        id_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [CW-1:0]             count_r, idx_r, pos_r;
  logic                      posset_r;
  logic [spl_pkg::ST_W-1:0]  st_r;
  logic [ID_BITS-1:0]        pop_id_r;
  logic [KEY_BITS-1:0]       pop_key_r;
  logic [KEY_BITS-1:0]       rd_key_r;
  logic [ID_BITS-1:0]        rd_id_r;
  logic                      out_valid_r;
  logic [spl_pkg::ST_W-1:0]  out_status_r;
  logic [ID_BITS-1:0]        out_id_r;
  logic [KEY_BITS-1:0]       out_cost_r;
  logic [spl_pkg::OCC_W-1:0] out_occ_r;

  logic [CW-1:0]       idx_m1, idx_p1;
  logic [CW:0]         idx_p1_w;
  logic                rd_en, wr_en;
  logic [AW-1:0]       raddr;
  logic [KEY_BITS-1:0] wr_key;
  logic [ID_BITS-1:0]  wr_id;
  logic                emit;

  assign idx_m1   = idx_r - CW'(1);
  assign idx_p1   = idx_r + CW'(1);
  assign idx_p1_w = {1'b0, idx_r} + (CW + 1)'(1);
  assign emit     = (ctl.uop == spl_pkg::UOP_EMIT);

  always_comb begin
    rd_en  = 1'b0;
    wr_en  = 1'b0;
    raddr  = idx_r[AW-1:0];
    wr_key = rd_key_r;
    wr_id  = rd_id_r;
    unique case (ctl.uop)
      spl_pkg::UOP_RD_CUR:  rd_en = 1'b1;
      spl_pkg::UOP_RD_PREV: begin
        rd_en = 1'b1;
        raddr = idx_m1[AW-1:0];
      end
      spl_pkg::UOP_RD_NEXT: begin
        rd_en = 1'b1;
        raddr = idx_p1[AW-1:0];
      end
      spl_pkg::UOP_WR_DOWN, spl_pkg::UOP_WR_UP: wr_en = 1'b1;
      spl_pkg::UOP_PUT_NEW, spl_pkg::UOP_INS_PUT: begin
        wr_en  = 1'b1;
        wr_key = key_r;
        wr_id  = id_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[idx_r[AW-1:0]] <= wr_key;
      ids_mem[idx_r[AW-1:0]]  <= wr_id;
    end
    if (rd_en) begin
      rd_key_r <= keys_mem[raddr];
      rd_id_r  <= ids_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      posset_r    <= 1'b0;
      st_r        <= spl_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctl.uop)
        spl_pkg::UOP_LOAD: begin
          idx_r    <= '0;
          posset_r <= 1'b0;
          st_r     <= spl_pkg::ST_OK;
        end
        spl_pkg::UOP_ST_PRESENT: st_r <= spl_pkg::ST_PRESENT;
        spl_pkg::UOP_ST_NFOUND:  st_r <= spl_pkg::ST_NOT_FOUND;
        spl_pkg::UOP_ST_FULL:    st_r <= spl_pkg::ST_FULL;
        spl_pkg::UOP_ST_EMPTY:   st_r <= spl_pkg::ST_EMPTY;
        spl_pkg::UOP_CLEAR:      count_r <= '0;
        spl_pkg::UOP_SCAN_STEP: begin
          if (!posset_r && (key_r < rd_key_r)) begin
            pos_r    <= idx_r;
            posset_r <= 1'b1;
          end
          idx_r <= idx_p1;
        end
        spl_pkg::UOP_INS_START: begin
          if (!posset_r) begin
            pos_r <= count_r;
          end
          idx_r <= count_r;
        end
        spl_pkg::UOP_WR_DOWN: idx_r <= idx_m1;
        spl_pkg::UOP_WR_UP:   idx_r <= idx_p1;
        spl_pkg::UOP_INS_PUT: count_r <= count_r + CW'(1);
        spl_pkg::UOP_CNT_DEC: count_r <= count_r - CW'(1);
        spl_pkg::UOP_POP_CAP: idx_r <= '0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.uop == spl_pkg::UOP_LOAD) begin
      cmd_r     <= in_cmd;
      id_r      <= in_entry_id;
      key_r     <= in_cost_key;
      pop_id_r  <= '0;
      pop_key_r <= '0;
    end else if (ctl.uop == spl_pkg::UOP_POP_CAP) begin
      pop_id_r  <= rd_id_r;
      pop_key_r <= rd_key_r;
    end
    if (emit) begin
      out_status_r <= st_r;
      out_id_r     <= pop_id_r;
      out_cost_r   <= pop_key_r;
      out_occ_r    <= spl_pkg::OCC_W'(count_r);
    end
  end

  assign stat.cmd          = cmd_r;
  assign stat.count_zero   = (count_r == '0);
  assign stat.full         = (count_r == CW'(CAPACITY));
  assign stat.idx_eq_count = (idx_r == count_r);
  assign stat.idx_eq_pos   = (idx_r == pos_r);
  assign stat.idx_zero     = (idx_r == '0);
  assign stat.idx_last     = (idx_p1_w >= {1'b0, count_r});
  assign stat.id_match     = (rd_id_r == id_r);
  assign stat.key_lt       = (key_r < rd_key_r);
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_r;
  assign out_cost      = out_cost_r;
  assign out_occupancy = out_occ_r;
endmodule

// ===== sv/sorted_priority_list_core.sv =====
`timescale 1ns / 1ps
// Clear, pop of an empty list and unused codes go from dispatch straight to the result;
// other commands walk the slots (scan for the id, then shift; pop only shifts).
// One item is worked on at a time; the single-port slot memory walk sets the rate.
// A new item is taken while a finished result still waits at the output register.
// Reset (rst_n low, synchronous): list empty, controller idle, no result pending.
module sorted_priority_list_core #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [spl_pkg::CMD_W-1:0] in_cmd,
  input  logic [ID_BITS-1:0]        in_entry_id,
  input  logic [KEY_BITS-1:0]       in_cost_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [spl_pkg::ST_W-1:0]  out_status,
  output logic [ID_BITS-1:0]        out_id,
  output logic [KEY_BITS-1:0]       out_cost,
  output logic [spl_pkg::OCC_W-1:0] out_occupancy
);
`include "sorted_priority_list_core_macros.svh"

  // Controller sequences the memory walk; datapath holds the slot memory,
  // the list count, the walk pointer and the result register.
  spl_pkg::ctl_cmd_t ctl;
  spl_pkg::dp_stat_t stat;

  // result flags watched by the checks below
  logic rsp_full;
  logic rsp_fail;

  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  spl_datapath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_entry_id   (in_entry_id),
    .in_cost_key   (in_cost_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_cost      (out_cost),
    .out_occupancy (out_occupancy)
  );

  assign rsp_full = out_valid && (out_status == spl_pkg::ST_FULL);
  assign rsp_fail = out_valid && (out_status != spl_pkg::ST_OK);

  // an accepted item keeps the input side closed while it is worked on
  `SPL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // a full status reports a list at capacity
  `SPL_ASSERT_IMPL(a_full_occ, clk, rst_n, rsp_full, out_occupancy == spl_pkg::OCC_W'(CAPACITY))
  // only a successful pop carries id and cost
  `SPL_ASSERT_IMPL(a_zero_payload, clk, rst_n, rsp_fail, out_id == '0 && out_cost == '0)
endmodule
